@@ sv/swlp_pkg.sv @@
// Shared constants, types and helper functions of the serial weight line parser.
package swlp_pkg;

    // Default line limit, including the slot that a newline would take.
    localparam int LINE_MAX_DEF = 64;

    // Token length limit and number of fraction digits kept.
    localparam int TOKEN_MAX   = 15;
    localparam int FRAC_DIGITS = 3;

    // Field widths.
    localparam int BYTE_W   = 8;
    localparam int WEIGHT_W = 32;
    localparam int TOKEN_W  = 4;
    localparam int FRAC_W   = 2;
    localparam int ACC_W    = WEIGHT_W + 1;
    localparam int ACC10_W  = ACC_W + 4;
    localparam int SCALE_W  = 10;
    localparam int SCALED_W = ACC_W + SCALE_W;

    // Accumulator clamp: one above the largest output value.
    localparam logic [ACC_W-1:0] ACC_CLAMP = {1'b1, {WEIGHT_W{1'b0}}};

    // Character codes.
    localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'd0;
    localparam logic [BYTE_W-1:0] CHAR_NL    = 8'd10;
    localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'd45;
    localparam logic [BYTE_W-1:0] CHAR_DOT   = 8'd46;
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'd57;

    // Scan phase of the current line.
    typedef enum logic [1:0] {
        PHASE_SEEK,
        PHASE_NUMBER,
        PHASE_STOP
    } phase_t;

    // Result of one processed byte, passed from the scanner to the output register.
    typedef struct packed {
        logic                valid;
        logic [WEIGHT_W-1:0] weight;
    } weight_result_t;

    // Factor that brings a value with k fraction digits to thousandths.
    function automatic logic [SCALE_W-1:0] scale_factor(input logic [FRAC_W-1:0] k);
        logic [SCALE_W-1:0] f;
        begin
            case (k)
                2'd0:    f = 10'd1000;
                2'd1:    f = 10'd100;
                2'd2:    f = 10'd10;
                default: f = 10'd1;
            endcase
            return f;
        end
    endfunction

endpackage

@@ sv/swlp_rx_if.sv @@
// Channel interface carrying received bytes.
interface swlp_rx_if;
    logic                          valid;
    logic                          ready;
    logic [swlp_pkg::BYTE_W-1:0]   rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ sv/swlp_weight_if.sv @@
// Channel interface carrying parsed weights.
interface swlp_weight_if;
    logic                          valid;
    logic                          ready;
    logic [swlp_pkg::WEIGHT_W-1:0] weight_milli;

    modport source (output valid, output weight_milli, input ready);
    modport sink   (input valid, input weight_milli, output ready);
endinterface

@@ sv/swlp_scan.sv @@
// Line and number scanner: holds the per-line state and forms the weight on a newline.
module swlp_scan #(
    parameter int LINE_MAX = swlp_pkg::LINE_MAX_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step,
    input  logic [swlp_pkg::BYTE_W-1:0]     rx_byte,
    output swlp_pkg::weight_result_t        result
);
    import swlp_pkg::*;

    localparam int LINE_W = (LINE_MAX > 2) ? $clog2(LINE_MAX) : 1;
    localparam logic [LINE_W-1:0] LINE_LAST = LINE_W'(LINE_MAX - 1);

    logic [LINE_W-1:0]  line_length_reg, line_length_next;
    phase_t             phase_reg, phase_next;
    logic               minus_seen_reg, minus_seen_next;
    logic               point_seen_reg, point_seen_next;
    logic               digit_seen_reg, digit_seen_next;
    logic               nonzero_seen_reg, nonzero_seen_next;
    logic [TOKEN_W-1:0] token_chars_reg, token_chars_next;
    logic [FRAC_W-1:0]  frac_digits_reg, frac_digits_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;

    logic               is_digit;
    logic [3:0]         digit_val;
    logic [ACC10_W-1:0] acc_times10;
    logic [ACC_W-1:0]   acc_digit;
    logic [SCALED_W-1:0] scaled;
    logic [WEIGHT_W-1:0] weight_sat;

    // Digit decode and accumulator update with clamping.
    always_comb
    begin
        is_digit    = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
        digit_val   = 4'(rx_byte - CHAR_ZERO);
        acc_times10 = {acc_reg, 3'b000} + {2'b00, acc_reg, 1'b0} + ACC10_W'(digit_val);
        acc_digit   = (acc_times10 > ACC10_W'(ACC_CLAMP)) ? ACC_CLAMP : ACC_W'(acc_times10);
    end

    // Scaling to thousandths with saturation at the top of the output field.
    always_comb
    begin
        scaled     = SCALED_W'(acc_reg) * SCALED_W'(scale_factor(frac_digits_reg));
        weight_sat = (scaled[SCALED_W-1:WEIGHT_W] != '0) ? '1 : scaled[WEIGHT_W-1:0];
    end

    // Next state of the line and scan, and the result of a newline.
    always_comb
    begin
        line_length_next  = line_length_reg;
        phase_next        = phase_reg;
        minus_seen_next   = minus_seen_reg;
        point_seen_next   = point_seen_reg;
        digit_seen_next   = digit_seen_reg;
        nonzero_seen_next = nonzero_seen_reg;
        token_chars_next  = token_chars_reg;
        frac_digits_next  = frac_digits_reg;
        acc_next          = acc_reg;
        result.valid      = 1'b0;
        result.weight     = weight_sat;

        if (step)
        begin
            if ((rx_byte == CHAR_NL) || (line_length_reg >= LINE_LAST))
            begin
                // A newline closes the line; an overflowing byte drops it.
                if (rx_byte == CHAR_NL)
                begin
                    result.valid = digit_seen_reg && !(minus_seen_reg && nonzero_seen_reg);
                end
                line_length_next  = '0;
                phase_next        = PHASE_SEEK;
                minus_seen_next   = 1'b0;
                point_seen_next   = 1'b0;
                digit_seen_next   = 1'b0;
                nonzero_seen_next = 1'b0;
                token_chars_next  = '0;
                frac_digits_next  = '0;
                acc_next          = '0;
            end
            else
            begin
                line_length_next = line_length_reg + 1'b1;
                if (phase_reg != PHASE_STOP)
                begin
                    if ((rx_byte == CHAR_NUL) || (token_chars_reg >= TOKEN_W'(TOKEN_MAX)))
                    begin
                        phase_next = PHASE_STOP;
                    end
                    else if (is_digit)
                    begin
                        // Fraction digits beyond the kept count are dropped.
                        if (!point_seen_reg || (frac_digits_reg < FRAC_W'(FRAC_DIGITS)))
                        begin
                            acc_next = acc_digit;
                        end
                        if (point_seen_reg && (frac_digits_reg < FRAC_W'(FRAC_DIGITS)))
                        begin
                            frac_digits_next = frac_digits_reg + 1'b1;
                        end
                        if (digit_val != 4'd0)
                        begin
                            nonzero_seen_next = 1'b1;
                        end
                        digit_seen_next  = 1'b1;
                        phase_next       = PHASE_NUMBER;
                        token_chars_next = token_chars_reg + 1'b1;
                    end
                    else if ((rx_byte == CHAR_DOT) && !point_seen_reg && digit_seen_reg)
                    begin
                        point_seen_next  = 1'b1;
                        token_chars_next = token_chars_reg + 1'b1;
                    end
                    else if ((rx_byte == CHAR_MINUS) && !digit_seen_reg && !minus_seen_reg)
                    begin
                        minus_seen_next  = 1'b1;
                        token_chars_next = token_chars_reg + 1'b1;
                    end
                    else if (digit_seen_reg)
                    begin
                        phase_next = PHASE_STOP;
                    end
                end
            end
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_length_reg  <= '0;
            phase_reg        <= PHASE_SEEK;
            minus_seen_reg   <= 1'b0;
            point_seen_reg   <= 1'b0;
            digit_seen_reg   <= 1'b0;
            nonzero_seen_reg <= 1'b0;
            token_chars_reg  <= '0;
            frac_digits_reg  <= '0;
            acc_reg          <= '0;
        end
        else
        begin
            line_length_reg  <= line_length_next;
            phase_reg        <= phase_next;
            minus_seen_reg   <= minus_seen_next;
            point_seen_reg   <= point_seen_next;
            digit_seen_reg   <= digit_seen_next;
            nonzero_seen_reg <= nonzero_seen_next;
            token_chars_reg  <= token_chars_next;
            frac_digits_reg  <= frac_digits_next;
            acc_reg          <= acc_next;
        end
    end

endmodule

@@ sv/serial_weight_line_parser_core.sv @@
// Top level of the serial weight line parser: input register, scanner and output register.
//
// Usage:
//   rx carries received bytes, one per transaction; a byte of 10 ends a line.
//   weight carries one transaction per newline whose line held a non-negative
//   number, giving the value in thousandths, truncated and saturated.
//   A byte goes into the input register when accepted and is scanned from
//   there; a newline waits while the output register is full. The weight
//   is registered in the output register when its newline is scanned.
//   One byte is accepted per cycle when the receiver keeps up.
//   The rate is set by the single scanner update per byte; the output
//   register lets bytes that give no weight keep flowing while a weight waits.
//   When the receiver stalls with a weight pending, a newline held in the
//   input register waits and rx is held off until the weight is taken.
//   Reset clears the line state and both registers' valid flags; the block
//   accepts bytes as soon as reset is released.
module serial_weight_line_parser_core #(
    parameter int LINE_MAX = swlp_pkg::LINE_MAX_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    swlp_rx_if.sink      rx,
    swlp_weight_if.source weight
);
    import swlp_pkg::*;

    logic                rx_valid_reg, rx_valid_next;
    logic [BYTE_W-1:0]   rx_byte_reg;
    logic                out_valid_reg, out_valid_next;
    logic [WEIGHT_W-1:0] weight_reg;
    logic                out_free;
    logic                step;
    weight_result_t      result;

    // Hand the held byte to the scanner unless it is a newline with no room for its weight.
    always_comb
    begin
        out_free       = !out_valid_reg || weight.ready;
        step           = rx_valid_reg && (out_free || (rx_byte_reg != CHAR_NL));
        rx.ready       = !rx_valid_reg || step;
        rx_valid_next  = rx.ready ? rx.valid : rx_valid_reg;
        out_valid_next = result.valid ? 1'b1 : (weight.ready ? 1'b0 : out_valid_reg);
    end

    swlp_scan #(
        .LINE_MAX (LINE_MAX)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (rx_byte_reg),
        .result  (result)
    );

    // Valid flags of the input and output registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rx_valid_reg  <= rx_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload of the input and output registers.
    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            rx_byte_reg <= rx.rx_byte;
        end
        if (result.valid)
        begin
            weight_reg <= result.weight;
        end
    end

    assign weight.valid        = out_valid_reg;
    assign weight.weight_milli = weight_reg;

endmodule

@@ tb/swlp_weight_checker.sv @@
// Checker for the serial weight line parser: predicts each weight from the received bytes and compares.
module swlp_weight_checker (
    input  logic   clk,
    input  logic   rst_n,
    swlp_rx_if     rx,
    swlp_weight_if weight,
    output int     fail_count,
    output int     pending_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import swlp_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // Predicted line and token state; all but the line length kept at the widths of the block.
    logic [6:0]          line_len;
    phase_t              scan_phase;
    logic                minus_seen;
    logic                point_seen;
    logic                digit_seen;
    logic                nonzero_seen;
    logic [TOKEN_W-1:0]  token_count;
    logic [FRAC_W-1:0]   frac_count;
    logic [ACC_W-1:0]    digit_acc;

    // Weights still owed by the block, oldest first.
    logic [WEIGHT_W-1:0] weights_due[$];
    int                  mismatches = 0;

    // Forget the current token and go back to looking for one.
    function automatic void clear_token();
        scan_phase   = PHASE_SEEK;
        minus_seen   = 1'b0;
        point_seen   = 1'b0;
        digit_seen   = 1'b0;
        nonzero_seen = 1'b0;
        token_count  = '0;
        frac_count   = '0;
        digit_acc    = '0;
    endfunction

    // Fold one decimal digit into the accumulator; surplus fraction digits are dropped.
    function automatic void take_digit(input logic [3:0] d);
        logic               keep;
        logic [ACC10_W-1:0] wide;
        keep = 1'b1;
        if (point_seen)
        begin
            if (frac_count < FRAC_DIGITS)
                frac_count = frac_count + 1'b1;
            else
                keep = 1'b0;
        end
        if (keep)
        begin
            wide = ACC10_W'(digit_acc) * ACC10_W'(10) + ACC10_W'(d);
            digit_acc = (wide > ACC10_W'(ACC_CLAMP)) ? ACC_CLAMP : wide[ACC_W-1:0];
        end
        if (d != 4'd0)
            nonzero_seen = 1'b1;
        digit_seen  = 1'b1;
        scan_phase  = PHASE_NUMBER;
        token_count = token_count + 1'b1;
    endfunction

    // Token scanner for one byte that has been stored in the line.
    function automatic void scan_char(input logic [BYTE_W-1:0] c);
        if (scan_phase == PHASE_STOP)
            return;
        if (c == CHAR_NUL || token_count >= TOKEN_MAX)
            scan_phase = PHASE_STOP;
        else if (c >= CHAR_ZERO && c <= CHAR_NINE)
            take_digit(4'(c - CHAR_ZERO));
        else if (c == CHAR_DOT && !point_seen && digit_seen)
        begin
            point_seen  = 1'b1;
            token_count = token_count + 1'b1;
        end
        else if (c == CHAR_MINUS && !digit_seen && !minus_seen)
        begin
            minus_seen  = 1'b1;
            token_count = token_count + 1'b1;
        end
        else if (digit_seen)
            scan_phase = PHASE_STOP;
    endfunction

    // Token value brought to thousandths and saturated to the output width.
    function automatic logic [WEIGHT_W-1:0] thousandths();
        logic [63:0] v;
        int          k;
        v = 64'(digit_acc);
        for (k = int'(frac_count); k < FRAC_DIGITS; k++)
            v = v * 64'd10;
        return (v > 64'hFFFF_FFFF) ? '1 : v[WEIGHT_W-1:0];
    endfunction

    // Line handling for one accepted byte; a newline may owe a weight.
    function automatic void advance_line(input logic [BYTE_W-1:0] c);
        if (c == CHAR_NL)
        begin
            if (digit_seen && !(minus_seen && nonzero_seen))
                weights_due.push_back(thousandths());
            line_len = '0;
            clear_token();
        end
        else if (int'(line_len) < LINE_MAX_DEF - 1)
        begin
            line_len = line_len + 1'b1;
            scan_char(c);
        end
        else
        begin
            line_len = '0;
            clear_token();
        end
    endfunction

    // Counts a mismatch and tells whether it is still to be reported in full.
    function automatic bit count_mismatch();
        mismatches++;
        return mismatches <= REPORT_LIMIT;
    endfunction

    // Compare weight transactions and predict from rx transactions at each edge.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            line_len = '0;
            clear_token();
            weights_due.delete();
        end
        else
        begin
            if (weight.valid && weight.ready)
            begin
                if (weights_due.size() == 0)
                begin
                    if (count_mismatch())
                        $display("%0t ns: weight %0d arrived with none expected",
                                 $time, weight.weight_milli);
                end
                else
                begin
                    if (weight.weight_milli !== weights_due[0])
                    begin
                        if (count_mismatch())
                            $display("%0t ns: weight_milli expected %0d, got %0d",
                                     $time, weights_due[0], weight.weight_milli);
                    end
                    void'(weights_due.pop_front());
                end
            end
            if (rx.valid && rx.ready)
                advance_line(rx.rx_byte);
        end
        pending_count <= weights_due.size();
        fail_count    <= mismatches;
    end

endmodule

@@ tb/tb_serial_weight_line_parser_core.sv @@
// Testbench top of the serial weight line parser: clock, reset, byte stimulus and verdict.
module tb_serial_weight_line_parser_core;
    timeunit 1ns;
    timeprecision 1ps;
    import swlp_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_BYTES = 1600;
    localparam int SETTLE       = 8;
    localparam logic [BYTE_W-1:0] CHAR_CR = 8'd13;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_count;
    int   send_idle_pct = 6;
    int   recv_idle_pct;
    int   hold_req;
    int   hold_ack;
    int   hold_left;
    int   bytes_sent;
    int   cycle_count;

    swlp_rx_if     rx_ch();
    swlp_weight_if weight_ch();

    serial_weight_line_parser_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_ch),
        .weight (weight_ch)
    );

    swlp_weight_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx            (rx_ch),
        .weight        (weight_ch),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Run limit: a hung handshake ends the run here.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("serial_weight_line_parser_core verification failed");
        $finish;
    end

    // Weight receiver: random stalls, plus a long hold-off when one is requested.
    initial
    begin
        weight_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_ack)
            begin
                hold_ack  = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                weight_ch.ready <= 1'b0;
            end
            else
                weight_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // One byte transaction, after a random number of idle cycles.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (!rx_ch.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_repeated(input logic [BYTE_W-1:0] b, input int n);
        int i;
        for (i = 0; i < n; i++)
            send_byte(b);
    endtask

    // Stop offering bytes until every predicted weight has come out.
    task automatic wait_all_weights();
        rx_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    function automatic logic [BYTE_W-1:0] filler_byte();
        string set;
        set = "ST,GS:+ kgNn.-";
        return set[$urandom_range(set.len() - 1)];
    endfunction

    function automatic logic [BYTE_W-1:0] digit_byte();
        return CHAR_ZERO + BYTE_W'($urandom_range(9));
    endfunction

    // A random line: mostly a scale reading with random content, the rest noise.
    task automatic send_random_line();
        int  kind;
        int  n;
        int  i;
        bit  all_zero;
        string mix;
        mix  = "0123456789.-";
        kind = $urandom_range(99);
        if (kind < 70)
        begin
            n = $urandom_range(4);
            for (i = 0; i < n; i++)
                send_byte(filler_byte());
            if ($urandom_range(3) == 0)
                send_byte(CHAR_MINUS);
            all_zero = ($urandom_range(5) == 0);
            n = ($urandom_range(9) == 0) ? $urandom_range(14, 7) : $urandom_range(6, 1);
            for (i = 0; i < n; i++)
                send_byte(all_zero ? CHAR_ZERO : digit_byte());
            if ($urandom_range(9) < 6)
            begin
                send_byte(CHAR_DOT);
                n = $urandom_range(5);
                for (i = 0; i < n; i++)
                    send_byte(all_zero ? CHAR_ZERO : digit_byte());
            end
            if ($urandom_range(1) == 1)
                send_text(" kg");
            if ($urandom_range(1) == 1)
                send_byte(CHAR_CR);
        end
        else if (kind < 85)
        begin
            n = $urandom_range(24);
            for (i = 0; i < n; i++)
                send_byte(BYTE_W'($urandom_range(255)));
        end
        else if (kind < 93)
        begin
            // Long lines around the line limit.
            n = $urandom_range(70, 58);
            for (i = 0; i < n; i++)
                send_byte(($urandom_range(3) == 0) ? digit_byte() : filler_byte());
        end
        else
        begin
            n = $urandom_range(20);
            for (i = 0; i < n; i++)
                send_byte(mix[$urandom_range(mix.len() - 1)]);
        end
        send_byte(CHAR_NL);
    endtask

    // Stimulus and verdict.
    initial
    begin
        int base;
        int phase_no;
        rst_n         <= 1'b0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= '0;
        recv_idle_pct <= 69;
        hold_req      <= 0;
        bytes_sent    = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed lines: field extremes and each special case.
        send_text("12.5\n");
        send_text("weight: 0.5 kg\r\n");
        send_text("-0\n");
        send_text("-0.000\n");
        send_text("-1\n");
        send_text("-0.0001\n");
        send_text("abc\n");
        send_text("\n");
        send_text(".5\n");
        send_text("--5\n");
        send_text("1.23456\n");
        send_text("4294967.295\n");
        send_text("4294967.296\n");
        send_text("99999999999\n");
        send_text("1.2.3\n");
        send_text("1-2\n");
        send_text("5\r\n");
        // Zero byte stops the scan, after a digit and before one.
        send_text("12");
        send_byte(CHAR_NUL);
        send_text(" 34\n");
        send_byte(CHAR_NUL);
        send_text(" 7\n");
        // Fifteen token characters of minus zero, then a digit past the limit.
        send_text("-00000000000000");
        send_text("1\n");
        send_byte(8'hFF);
        send_byte(8'h80);
        send_text("1\n");
        // A line that just fits, then one that overflows on the 9, leaving 8 to start a new line.
        send_repeated("x", LINE_MAX_DEF - 2);
        send_text("3\n");
        send_repeated("x", LINE_MAX_DEF - 1);
        send_text("98\n");
        wait_all_weights();

        // Random lines in three idling phases.
        base = bytes_sent;
        for (phase_no = 0; phase_no < 3; phase_no++)
        begin
            case (phase_no)
                0:
                begin
                    send_idle_pct = 6;
                    recv_idle_pct <= 69;
                end
                1:
                begin
                    send_idle_pct = 69;
                    recv_idle_pct <= 6;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct <= 0;
                    hold_req      <= hold_req + 1;
                end
            endcase
            while (bytes_sent < base + (phase_no + 1) * RANDOM_BYTES / 3)
                send_random_line();
            wait_all_weights();
        end

        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("serial_weight_line_parser_core verification clean");
        else
            $display("serial_weight_line_parser_core verification failed");
        $finish;
    end

endmodule
